// ----- rtl/bsra_pkg.sv -----
`timescale 1ns / 1ps

package bsra_pkg;

    // Fixed field widths of the request and result beats.
    localparam int FUNC_W   = 1;
    localparam int SET_W    = 3;
    localparam int SLOT_W   = 6;
    localparam int KIND_W   = 3;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    // Width that holds first_slot + slot_count without overflow.
    localparam int SPAN_W = SLOT_W + 1;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_RESERVE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOCATE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_PAST_END = 2'd1,
        ST_CLASH    = 2'd2,
        ST_NO_RUN   = 2'd3
    } status_t;

    // One result beat as handed from the sequencer to the output stage.
    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   base;
    } res_t;

endpackage

// ----- rtl/bsra_ram.sv -----
`timescale 1ns / 1ps

module bsra_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port; read data arrives in the cycle after re.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bsra_ctrl.sv -----
`timescale 1ns / 1ps

module bsra_ctrl #(
    parameter int MAX_SLOTS  = 32,
    parameter int NUM_SETS   = 8,
    parameter int OWNER_BITS = 16,
    localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int OFF_W   = IDX_W,
    localparam int OWN_W   = (OWNER_BITS < bsra_pkg::ID_W) ? OWNER_BITS : bsra_pkg::ID_W,
    localparam int ATTR_W  = bsra_pkg::KIND_W + OWN_W + OFF_W,
    localparam int DEPTH   = NUM_SETS * MAX_SLOTS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int ROW_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsra_pkg::FUNC_W-1:0]   func,
    input  logic [bsra_pkg::SET_W-1:0]    set_index,
    input  logic [bsra_pkg::SLOT_W-1:0]   first_slot,
    input  logic [bsra_pkg::SLOT_W-1:0]   slot_count,
    input  logic [bsra_pkg::KIND_W-1:0]   owner_kind,
    input  logic [bsra_pkg::ID_W-1:0]     owner_id,
    // Occupancy row memory, one row of taken bits per set.
    output logic                          row_we,
    output logic [ROW_AW-1:0]             row_waddr,
    output logic [MAX_SLOTS-1:0]          row_wdata,
    output logic                          row_re,
    output logic [ROW_AW-1:0]             row_raddr,
    input  logic [MAX_SLOTS-1:0]          row_rdata,
    // Slot attribute memory: kind, owner and offset per slot.
    output logic                          attr_we,
    output logic [AW-1:0]                 attr_waddr,
    output logic [ATTR_W-1:0]             attr_wdata,
    output logic                          attr_re,
    output logic [AW-1:0]                 attr_raddr,
    input  logic [ATTR_W-1:0]             attr_rdata,
    // Finished result toward the output stage.
    output logic                          res_valid,
    output bsra_pkg::res_t                res,
    input  logic                          res_take
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        LOAD,
        RES,
        SCAN,
        CLAIM,
        WB,
        DONE
    } state_t;

    state_t state_reg, state_next;
    logic [ROW_AW-1:0] clr_idx_reg, clr_idx_next;

    // Request and working registers (no reset needed).
    logic [bsra_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [ROW_AW-1:0]           set_reg, set_next;
    logic [bsra_pkg::SLOT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [bsra_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [OWN_W-1:0]            owner_reg, owner_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [MAX_SLOTS-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]            end_reg, end_next;
    logic [CNT_W-1:0]            run_start_reg, run_start_next;
    logic [CNT_W-1:0]            run_len_reg, run_len_next;
    bsra_pkg::status_t           res_status_reg, res_status_next;
    logic [bsra_pkg::SLOT_W-1:0] res_base_reg, res_base_next;

    // Decoded helpers.
    logic                        in_accept;
    logic                        set_ok;
    logic [bsra_pkg::SPAN_W-1:0] span_end;
    logic [IDX_W-1:0]            chk_slot;
    logic [IDX_W-1:0]            idx_slot;
    logic [IDX_W-1:0]            wr_slot;
    logic [OFF_W-1:0]            chk_off;
    logic [OFF_W-1:0]            claim_off;
    logic [bsra_pkg::KIND_W-1:0] rd_kind;
    logic [OWN_W-1:0]            rd_owner;
    logic [OFF_W-1:0]            rd_off;
    logic                        mismatch;

    assign in_stall  = (state_reg != IDLE);
    assign in_accept = in_valid && !in_stall;
    assign set_ok    = (32'(set_index) < 32'(NUM_SETS));
    assign span_end  = bsra_pkg::SPAN_W'(first_slot) + bsra_pkg::SPAN_W'(slot_count);

    assign chk_slot  = chk_idx_reg[IDX_W-1:0];
    assign idx_slot  = idx_reg[IDX_W-1:0];
    assign wr_slot   = (state_reg == CLAIM) ? idx_slot : chk_slot;
    assign chk_off   = OFF_W'(chk_idx_reg - CNT_W'(first_reg));
    assign claim_off = OFF_W'(idx_reg - run_start_reg);

    // Stored attributes of the slot under check.
    assign rd_kind   = attr_rdata[ATTR_W-1 -: bsra_pkg::KIND_W];
    assign rd_owner  = attr_rdata[OFF_W +: OWN_W];
    assign rd_off    = attr_rdata[OFF_W-1:0];
    assign mismatch  = (rd_kind != kind_reg) || (rd_owner != owner_reg) || (rd_off != chk_off);

    assign res_valid  = (state_reg == DONE);
    assign res.status = res_status_reg;
    assign res.base   = res_base_reg;

    // Sequencer: next state, working registers and memory accesses.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        func_next       = func_reg;
        set_next        = set_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        owner_next      = owner_reg;
        base_next       = base_reg;
        row_next        = row_reg;
        idx_next        = idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        end_next        = end_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;

        row_we     = 1'b0;
        row_waddr  = set_reg;
        row_wdata  = row_reg;
        row_re     = 1'b0;
        row_raddr  = ROW_AW'(set_index);
        attr_we    = 1'b0;
        attr_waddr = base_reg + AW'(chk_idx_reg);
        attr_wdata = {kind_reg, owner_reg, chk_off};
        attr_re    = 1'b0;
        attr_raddr = base_reg + AW'(idx_reg);

        unique case (state_reg)
            CLEAR:
            begin
                // Empty one set row per cycle after reset.
                row_we    = 1'b1;
                row_waddr = clr_idx_reg;
                row_wdata = '0;
                clr_idx_next = clr_idx_reg + ROW_AW'(1);
                if (clr_idx_reg == ROW_AW'(NUM_SETS - 1))
                begin
                    state_next = IDLE;
                end
            end

            IDLE:
            begin
                if (in_accept)
                begin
                    func_next  = func;
                    set_next   = ROW_AW'(set_index);
                    first_next = first_slot;
                    count_next = CNT_W'(slot_count);
                    kind_next  = owner_kind;
                    owner_next = owner_id[OWN_W-1:0];
                    base_next  = AW'(32'(set_index) * 32'(MAX_SLOTS));
                    end_next   = CNT_W'(span_end);
                    row_re     = 1'b1;
                    if (func == bsra_pkg::FUNC_RESERVE)
                    begin
                        res_base_next = first_slot;
                        if (!set_ok || (span_end > bsra_pkg::SPAN_W'(MAX_SLOTS)))
                        begin
                            res_status_next = bsra_pkg::ST_PAST_END;
                            state_next      = DONE;
                        end
                        else if (slot_count == '0)
                        begin
                            res_status_next = bsra_pkg::ST_OK;
                            state_next      = DONE;
                        end
                        else
                        begin
                            state_next = LOAD;
                        end
                    end
                    else
                    begin
                        res_base_next = '0;
                        if (!set_ok ||
                            (bsra_pkg::SPAN_W'(slot_count) > bsra_pkg::SPAN_W'(MAX_SLOTS)))
                        begin
                            res_status_next = bsra_pkg::ST_NO_RUN;
                            state_next      = DONE;
                        end
                        else if (slot_count == '0)
                        begin
                            res_status_next = bsra_pkg::ST_OK;
                            state_next      = DONE;
                        end
                        else
                        begin
                            state_next = LOAD;
                        end
                    end
                end
            end

            LOAD:
            begin
                // The set's taken bits arrive from the row memory.
                row_next      = row_rdata;
                run_start_next = '0;
                run_len_next   = '0;
                if (func_reg == bsra_pkg::FUNC_RESERVE)
                begin
                    idx_next   = CNT_W'(first_reg);
                    state_next = RES;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = SCAN;
                end
            end

            RES:
            begin
                // Read stage: fetch the attributes of the next slot of the range.
                if (idx_reg < end_reg)
                begin
                    attr_re        = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg;
                    idx_next       = idx_reg + CNT_W'(1);
                end
                // Check stage: claim a free slot or compare a held one.
                if (chk_valid_reg)
                begin
                    if (!row_reg[chk_slot])
                    begin
                        attr_we           = 1'b1;
                        row_next[chk_slot] = 1'b1;
                    end
                    if (row_reg[chk_slot] && mismatch)
                    begin
                        res_status_next = bsra_pkg::ST_CLASH;
                        chk_valid_next  = 1'b0;
                        state_next      = WB;
                    end
                    else if ((chk_idx_reg + CNT_W'(1)) == end_reg)
                    begin
                        res_status_next = bsra_pkg::ST_OK;
                        chk_valid_next  = 1'b0;
                        state_next      = WB;
                    end
                end
            end

            SCAN:
            begin
                // First fit: walk the taken bits, tracking the current free run.
                idx_next = idx_reg + CNT_W'(1);
                if (row_reg[idx_slot])
                begin
                    run_start_next = idx_reg + CNT_W'(1);
                    run_len_next   = '0;
                    if (idx_reg == CNT_W'(MAX_SLOTS - 1))
                    begin
                        res_status_next = bsra_pkg::ST_NO_RUN;
                        state_next      = DONE;
                    end
                end
                else if ((run_len_reg + CNT_W'(1)) == count_reg)
                begin
                    end_next      = run_start_reg + count_reg;
                    idx_next      = run_start_reg;
                    res_base_next = bsra_pkg::SLOT_W'(run_start_reg);
                    state_next    = CLAIM;
                end
                else
                begin
                    run_len_next = run_len_reg + CNT_W'(1);
                    if (idx_reg == CNT_W'(MAX_SLOTS - 1))
                    begin
                        res_status_next = bsra_pkg::ST_NO_RUN;
                        state_next      = DONE;
                    end
                end
            end

            CLAIM:
            begin
                // Claim the found run one slot per cycle, offsets from zero.
                attr_we            = 1'b1;
                attr_waddr         = base_reg + AW'(idx_reg);
                attr_wdata         = {kind_reg, owner_reg, claim_off};
                row_next[idx_slot] = 1'b1;
                idx_next           = idx_reg + CNT_W'(1);
                if ((idx_reg + CNT_W'(1)) == end_reg)
                begin
                    res_status_next = bsra_pkg::ST_OK;
                    state_next      = WB;
                end
            end

            WB:
            begin
                // Write the updated taken bits back to the set's row.
                row_we     = 1'b1;
                state_next = DONE;
            end

            DONE:
            begin
                if (res_take)
                begin
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State, clear counter and check-valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Request and working datapath registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        set_reg        <= set_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        kind_reg       <= kind_next;
        owner_reg      <= owner_next;
        base_reg       <= base_next;
        row_reg        <= row_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        end_reg        <= end_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
    end

`ifndef SYNTH
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        attr_we |-> !row_reg[wr_slot])
        else $error("Attribute write to a slot that is already taken.");

    a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) |-> (run_len_reg < count_reg))
        else $error("Free run grew to the request size without a claim.");

    a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == RES) && chk_valid_reg) |-> (chk_idx_reg < end_reg))
        else $error("Reserve check beyond the requested range.");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CLEAR) |-> (!attr_we && !res_valid && in_stall))
        else $error("Activity during the reset clearing pass.");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_take) |=> (state_reg == IDLE))
        else $error("Sequencer did not return to idle after handing off a result.");
`endif

endmodule

// ----- rtl/binding_slot_range_allocator_top.sv -----
`timescale 1ns / 1ps

// Per-set contiguous slot range allocator.
// Request channel: in_valid / in_stall with func, set_index, first_slot,
// slot_count, owner_kind and owner_id. A beat is taken when in_valid is high
// and in_stall is low. func reserve claims a given range; func allocate
// claims the lowest free run of slot_count slots (first fit).
// Result channel: out_valid / out_stall with status and base_slot, exactly
// one result beat per request beat, in request order.
// A reserve does one attribute read and check per slot, pipelined, and
// stops early on a clash; an allocate walks one taken bit per cycle, then
// makes one claim write per slot. Rejected and empty requests skip the walk
// and go straight to the result. Requests are walked one at a time by a
// sequencer over a row memory of taken bits and a slot attribute memory;
// the next request can be taken in the cycle after the previous result
// moves to the output register, so an earlier result may wait there under
// out_stall while a second finished result waits inside the block.
// Reset: after rst_n rises, a clearing pass empties every set's occupancy
// row; in_stall stays high during it.

module binding_slot_range_allocator_top #(
    parameter int MAX_SLOTS  = 32,
    parameter int NUM_SETS   = 8,
    parameter int OWNER_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsra_pkg::FUNC_W-1:0]   func,
    input  logic [bsra_pkg::SET_W-1:0]    set_index,
    input  logic [bsra_pkg::SLOT_W-1:0]   first_slot,
    input  logic [bsra_pkg::SLOT_W-1:0]   slot_count,
    input  logic [bsra_pkg::KIND_W-1:0]   owner_kind,
    input  logic [bsra_pkg::ID_W-1:0]     owner_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bsra_pkg::STATUS_W-1:0] status,
    output logic [bsra_pkg::SLOT_W-1:0]   base_slot
);

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OWN_W  = (OWNER_BITS < bsra_pkg::ID_W) ? OWNER_BITS : bsra_pkg::ID_W;
    localparam int ATTR_W = bsra_pkg::KIND_W + OWN_W + IDX_W;
    localparam int DEPTH  = NUM_SETS * MAX_SLOTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    logic                 row_we;
    logic [ROW_AW-1:0]    row_waddr;
    logic [MAX_SLOTS-1:0] row_wdata;
    logic                 row_re;
    logic [ROW_AW-1:0]    row_raddr;
    logic [MAX_SLOTS-1:0] row_rdata;
    logic                 attr_we;
    logic [AW-1:0]        attr_waddr;
    logic [ATTR_W-1:0]    attr_wdata;
    logic                 attr_re;
    logic [AW-1:0]        attr_raddr;
    logic [ATTR_W-1:0]    attr_rdata;
    logic                 res_valid;
    bsra_pkg::res_t       res;
    logic                 res_take;

    logic                          out_valid_reg;
    logic [bsra_pkg::STATUS_W-1:0] status_reg;
    logic [bsra_pkg::SLOT_W-1:0]   base_slot_reg;

    // Request sequencer.
    bsra_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .NUM_SETS   (NUM_SETS),
        .OWNER_BITS (OWNER_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .set_index  (set_index),
        .first_slot (first_slot),
        .slot_count (slot_count),
        .owner_kind (owner_kind),
        .owner_id   (owner_id),
        .row_we     (row_we),
        .row_waddr  (row_waddr),
        .row_wdata  (row_wdata),
        .row_re     (row_re),
        .row_raddr  (row_raddr),
        .row_rdata  (row_rdata),
        .attr_we    (attr_we),
        .attr_waddr (attr_waddr),
        .attr_wdata (attr_wdata),
        .attr_re    (attr_re),
        .attr_raddr (attr_raddr),
        .attr_rdata (attr_rdata),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // Occupancy rows, one word of taken bits per set.
    bsra_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (MAX_SLOTS)
    ) u_row_mem (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Slot attributes: owner kind, owner id and offset within the range.
    bsra_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ATTR_W)
    ) u_attr_mem (
        .clk   (clk),
        .we    (attr_we),
        .waddr (attr_waddr),
        .wdata (attr_wdata),
        .re    (attr_re),
        .raddr (attr_raddr),
        .rdata (attr_rdata)
    );

    // Output register: take a result whenever the register is empty or drains.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg    <= res.status;
            base_slot_reg <= res.base;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign base_slot = base_slot_reg;

endmodule

// ----- dv/tb_binding_slot_range_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_binding_slot_range_allocator_top;

    localparam int MAX_SLOTS   = 32;
    localparam int NUM_SETS    = 8;
    localparam int OWNER_BITS  = 16;
    localparam int TABLE_DEPTH = MAX_SLOTS * NUM_SETS;
    localparam int DIRECTED_N  = 21;
    localparam int RANDOM_N    = 1330;
    localparam int CALM_TAIL   = 150;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 150;
    localparam int DRAIN_WAIT  = 100;

    // One request beat as the driver presents it.
    typedef struct {
        logic [bsra_pkg::FUNC_W-1:0] func;
        logic [bsra_pkg::SET_W-1:0]  set_index;
        logic [bsra_pkg::SLOT_W-1:0] first_slot;
        logic [bsra_pkg::SLOT_W-1:0] slot_count;
        logic [bsra_pkg::KIND_W-1:0] owner_kind;
        logic [bsra_pkg::ID_W-1:0]   owner_id;
    } slot_req_t;

    // A range known to be held whole by one owner, with offsets from zero.
    typedef struct {
        logic [bsra_pkg::SET_W-1:0]  set_index;
        logic [bsra_pkg::SLOT_W-1:0] first_slot;
        logic [bsra_pkg::SLOT_W-1:0] slot_count;
        logic [bsra_pkg::KIND_W-1:0] owner_kind;
        logic [bsra_pkg::ID_W-1:0]   owner_id;
    } held_range_t;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    logic [bsra_pkg::FUNC_W-1:0]   func       = bsra_pkg::FUNC_RESERVE;
    logic [bsra_pkg::SET_W-1:0]    set_index  = '0;
    logic [bsra_pkg::SLOT_W-1:0]   first_slot = '0;
    logic [bsra_pkg::SLOT_W-1:0]   slot_count = '0;
    logic [bsra_pkg::KIND_W-1:0]   owner_kind = '0;
    logic [bsra_pkg::ID_W-1:0]     owner_id   = '0;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    logic [bsra_pkg::STATUS_W-1:0] status;
    logic [bsra_pkg::SLOT_W-1:0]   base_slot;

    // Shadow of the occupancy table.
    bit                            occ_taken  [TABLE_DEPTH];
    logic [bsra_pkg::KIND_W-1:0]   occ_kind   [TABLE_DEPTH];
    logic [bsra_pkg::ID_W-1:0]     occ_owner  [TABLE_DEPTH];
    logic [4:0]                    occ_offset [TABLE_DEPTH];

    slot_req_t                     req_queue[$];
    bsra_pkg::res_t                expected_results[$];
    held_range_t                   held_ranges[$];

    int                            accepted_reqs  = 0;
    int                            fail_count     = 0;
    int                            send_gap       = 0;
    int                            recv_hold      = 0;
    bit                            long_hold_done = 1'b0;
    bit                            calm           = 1'b0;

    binding_slot_range_allocator_top #(
        .MAX_SLOTS  (MAX_SLOTS),
        .NUM_SETS   (NUM_SETS),
        .OWNER_BITS (OWNER_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .set_index  (set_index),
        .first_slot (first_slot),
        .slot_count (slot_count),
        .owner_kind (owner_kind),
        .owner_id   (owner_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .base_slot  (base_slot)
    );

    // Free-running clock.
    always #10 clk = ~clk;

    // Claim one slot in the shadow table.
    function automatic void claim_slot(input int idx, input slot_req_t r, input int off);
        occ_taken[idx]  = 1'b1;
        occ_kind[idx]   = r.owner_kind;
        occ_owner[idx]  = r.owner_id;
        occ_offset[idx] = off[4:0];
    endfunction

    // Apply a request to the shadow table and return the result it yields.
    function automatic bsra_pkg::res_t apply_slot_request(input slot_req_t r);
        bsra_pkg::res_t res;
        int             row;
        int             first;
        int             count;
        int             i;
        int             start;
        bit             done;
        bit             run_free;
        row        = int'(r.set_index) * MAX_SLOTS;
        first      = int'(r.first_slot);
        count      = int'(r.slot_count);
        done       = 1'b0;
        res.status = bsra_pkg::ST_OK;
        res.base   = r.first_slot;
        if (r.func == bsra_pkg::FUNC_RESERVE)
        begin
            if (first + count > MAX_SLOTS)
            begin
                res.status = bsra_pkg::ST_PAST_END;
            end
            else
            begin
                // Claim in order; a slot held any other way stops the walk.
                for (i = first; i < first + count && !done; i++)
                begin
                    if (!occ_taken[row + i])
                    begin
                        claim_slot(row + i, r, i - first);
                    end
                    else if (occ_kind[row + i] != r.owner_kind ||
                             occ_owner[row + i] != r.owner_id ||
                             int'(occ_offset[row + i]) != i - first)
                    begin
                        res.status = bsra_pkg::ST_CLASH;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // First fit: skip past each taken slot found in the window.
            res.status = bsra_pkg::ST_NO_RUN;
            res.base   = '0;
            start      = 0;
            while (!done && start + count <= MAX_SLOTS)
            begin
                run_free = 1'b1;
                for (i = start; i < start + count && run_free; i++)
                begin
                    if (occ_taken[row + i])
                    begin
                        run_free = 1'b0;
                        start = i + 1;
                    end
                end
                if (run_free)
                begin
                    for (i = start; i < start + count; i++)
                    begin
                        claim_slot(row + i, r, i - start);
                    end
                    res.status = bsra_pkg::ST_OK;
                    res.base   = start[bsra_pkg::SLOT_W-1:0];
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic slot_req_t make_req(input logic [bsra_pkg::FUNC_W-1:0] f,
                                           input int s, input int fs, input int cnt,
                                           input int k, input int id);
        slot_req_t r;
        r.func       = f;
        r.set_index  = s[bsra_pkg::SET_W-1:0];
        r.first_slot = fs[bsra_pkg::SLOT_W-1:0];
        r.slot_count = cnt[bsra_pkg::SLOT_W-1:0];
        r.owner_kind = k[bsra_pkg::KIND_W-1:0];
        r.owner_id   = id[bsra_pkg::ID_W-1:0];
        return r;
    endfunction

    // Mostly short counts so the tables fill slowly; a few reach the full row.
    function automatic int pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 4);
        else if (p < 95)
            return $urandom_range(5, 12);
        return $urandom_range(13, MAX_SLOTS);
    endfunction

    // Random request: allocations, replays of held ranges, broken replays and noise.
    function automatic slot_req_t make_random_req();
        slot_req_t   r;
        held_range_t h;
        int          p;
        int          q;
        p = $urandom_range(0, 99);
        r = make_req(bsra_pkg::FUNC_RESERVE, $urandom_range(0, NUM_SETS - 1),
                     $urandom_range(0, 31), pick_count(), $urandom_range(0, 5),
                     $urandom_range(0, 65535));
        if (p < 30)
        begin
            r.func       = bsra_pkg::FUNC_ALLOCATE;
            r.first_slot = bsra_pkg::SLOT_W'($urandom_range(0, 63));
        end
        else if (p < 70 && held_ranges.size() > 0)
        begin
            h = held_ranges[$urandom_range(0, held_ranges.size() - 1)];
            r.set_index  = h.set_index;
            r.first_slot = h.first_slot;
            r.slot_count = bsra_pkg::SLOT_W'($urandom_range(0, int'(h.slot_count)));
            r.owner_kind = h.owner_kind;
            r.owner_id   = h.owner_id;
            if (p >= 55)
            begin
                // Break the replay in one way.
                q = $urandom_range(0, 3);
                r.slot_count = h.slot_count;
                if (q == 0)
                    r.owner_kind = bsra_pkg::KIND_W'((int'(h.owner_kind) + 1) % 6);
                else if (q == 1)
                    r.owner_id = h.owner_id ^ (16'h1 << $urandom_range(0, bsra_pkg::ID_W - 1));
                else if (q == 2)
                    r.first_slot = h.first_slot + bsra_pkg::SLOT_W'(1);
                else
                    r.slot_count = h.slot_count + bsra_pkg::SLOT_W'($urandom_range(1, 4));
            end
        end
        else if (p < 90)
        begin
            if ($urandom_range(0, 4) == 0)
                r.first_slot = bsra_pkg::SLOT_W'($urandom_range(0, 63));
        end
        else
        begin
            r.func       = bsra_pkg::FUNC_W'($urandom_range(0, 1));
            r.first_slot = bsra_pkg::SLOT_W'($urandom_range(0, 63));
            r.slot_count = bsra_pkg::SLOT_W'($urandom_range(0, MAX_SLOTS));
        end
        return r;
    endfunction

    // Driver: presents queued requests and predicts each accepted one.
    always @(posedge clk)
    begin
        slot_req_t      r;
        bsra_pkg::res_t res;
        held_range_t    h;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r.func       = func;
                r.set_index  = set_index;
                r.first_slot = first_slot;
                r.slot_count = slot_count;
                r.owner_kind = owner_kind;
                r.owner_id   = owner_id;
                res = apply_slot_request(r);
                expected_results.push_back(res);
                accepted_reqs++;
                if (res.status == bsra_pkg::ST_OK && r.slot_count != 0)
                begin
                    h.set_index  = r.set_index;
                    h.first_slot = (r.func == bsra_pkg::FUNC_ALLOCATE) ? res.base
                                                                         : r.first_slot;
                    h.slot_count = r.slot_count;
                    h.owner_kind = r.owner_kind;
                    h.owner_id   = r.owner_id;
                    held_ranges.push_back(h);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 99) < 10)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    r = req_queue.pop_front();
                    func       <= r.func;
                    set_index  <= r.set_index;
                    first_slot <= r.first_slot;
                    slot_count <= r.slot_count;
                    owner_kind <= r.owner_kind;
                    owner_id   <= r.owner_id;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives the result stall.
    always @(posedge clk)
    begin
        bsra_pkg::res_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no request outstanding: status %0d base %0d",
                           status, base_slot);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        fail_count++;
                    end
                    if (base_slot !== want.base)
                    begin
                        $error("base_slot mismatch: expected %0d, actual %0d",
                               want.base, base_slot);
                        fail_count++;
                    end
                end
            end
            // One long hold-off fills the block so that it stalls requests.
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && accepted_reqs >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                recv_hold = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 12)
            begin
                recv_hold = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: empty ranges, a full row, clashes of every kind,
        // ranges past the end, a partial claim before a clash and first fit.
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 0, 0, 0, 0, 0));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 0, 0, 0, 0, 0));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 0, 0, 32, 5, 16'hffff));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 0, 0, 1, 1, 16'h0001));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 0, 0, 32, 5, 16'hffff));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 0, 1, 2, 5, 16'hffff));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 0, 0, 1, 4, 16'hffff));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 0, 0, 1, 5, 16'hfffe));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 1, 63, 32, 2, 16'h5555));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 1, 31, 2, 2, 16'h5555));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 1, 31, 1, 2, 16'haaaa));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 1, 32, 0, 3, 16'h0000));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 1, 33, 0, 3, 16'h0000));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 1, 0, 32, 3, 16'h00ff));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 1, 0, 31, 3, 16'hff00));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 2, 4, 4, 1, 16'h1234));
        req_queue.push_back(make_req(bsra_pkg::FUNC_RESERVE, 2, 2, 4, 1, 16'h1234));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 2, 0, 2, 0, 16'h4321));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 2, 0, 3, 4, 16'h8001));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 7, 0, 1, 0, 16'h0000));
        req_queue.push_back(make_req(bsra_pkg::FUNC_ALLOCATE, 3, 63, 32, 5, 16'h7fff));

        // Random requests, generated a few ahead so replays see held ranges.
        for (n = 0; n < RANDOM_N; n++)
        begin
            while (req_queue.size() >= 4)
                @(posedge clk);
            if (n >= RANDOM_N - CALM_TAIL)
                calm = 1'b1;
            req_queue.push_back(make_random_req());
        end

        // Drain: every request taken and every result seen.
        while (accepted_reqs < DIRECTED_N + RANDOM_N || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bsra_pkg.sv
rtl/bsra_ram.sv
rtl/bsra_ctrl.sv
rtl/binding_slot_range_allocator_top.sv
dv/tb_binding_slot_range_allocator_top.sv
